[hw/rtl/ordered_list_table_engine_defines.svh]
// ----------------------------------------------------------------------------
// Ordered list table engine: assertion macros
// Shared concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_TABLE_ENGINE_DEFINES_SVH
`define ORDERED_LIST_TABLE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define OLTE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OLTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OLTE_ASSERT(lbl, clk, rst_n, prop, msg)
`define OLTE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/olte_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered list table engine package
// Sizes, command and status codes, and the types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package olte_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DELETE  = 2'd1,
    ACT_SEARCH  = 2'd2,
    ACT_REVERSE = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_LOAD   = 3'd1,
    CELL_UP     = 3'd2,
    CELL_DOWN   = 3'd3,
    CELL_MIRROR = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] entry_count;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/olte_if.sv]
// ----------------------------------------------------------------------------
// Ordered list table engine channels
// Valid/ready command and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface olte_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [olte_pkg::ACT_W-1:0]                action;
  logic [olte_pkg::POS_W-1:0]                position;
  logic signed [olte_pkg::DATA_W-1:0]        value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface olte_out_if;
  logic                              valid;
  logic                              ready;
  logic [olte_pkg::STAT_W-1:0]       status;
  logic [olte_pkg::IDX_W-1:0]        found_index;
  logic [olte_pkg::CNT_W-1:0]        entry_count;

  modport source (output valid, status, found_index, entry_count, input ready);
  modport sink   (input valid, status, found_index, entry_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/olte_cell.sv]
// ----------------------------------------------------------------------------
// Ordered list table engine: list cell
// One list entry; loads, takes a neighbor or its mirror, and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module olte_cell (
  input  wire                              clk,
  input  wire olte_pkg::cell_ctrl_t        ctrl,
  input  wire [olte_pkg::DATA_W-1:0]       left_val,
  input  wire [olte_pkg::DATA_W-1:0]       right_val,
  input  wire [olte_pkg::DATA_W-1:0]       mirror_val,
  output logic [olte_pkg::DATA_W-1:0]      value,
  output logic                             match
);

  logic [olte_pkg::DATA_W-1:0] value_r;
  logic [olte_pkg::DATA_W-1:0] value_nxt;

  always_comb begin
    case (ctrl.op)
      olte_pkg::CELL_LOAD:   value_nxt = ctrl.key;
      olte_pkg::CELL_UP:     value_nxt = left_val;
      olte_pkg::CELL_DOWN:   value_nxt = right_val;
      olte_pkg::CELL_MIRROR: value_nxt = mirror_val;
      default:               value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign match = (value_r == ctrl.key);

endmodule

`default_nettype wire

[hw/rtl/olte_resbuf.sv]
// ----------------------------------------------------------------------------
// Ordered list table engine: result buffer
// Output register with a skid stage so commands flow while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_table_engine_defines.svh"

module olte_resbuf (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  input  wire olte_pkg::res_t        push_res,
  output logic                       full,
  output logic                       out_valid,
  input  wire                        out_ready,
  output olte_pkg::res_t             out_res
);

  logic           out_valid_r;
  logic           out_valid_nxt;
  logic           skid_valid_r;
  logic           skid_valid_nxt;
  olte_pkg::res_t out_res_r;
  olte_pkg::res_t out_res_nxt;
  olte_pkg::res_t skid_res_r;
  olte_pkg::res_t skid_res_nxt;
  logic           pop;

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = push;
        skid_res_nxt   = push_res;
      end else begin
        out_valid_nxt = push;
        out_res_nxt   = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `OLTE_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r, "skid word without output word")
  `OLTE_ASSERT(a_stall_fills_skid, clk, rst_n, (push && out_valid_r && !out_ready) |=> skid_valid_r, "stalled word lost")
  `OLTE_ASSERT(a_skid_drains, clk, rst_n, (pop && skid_valid_r) |=> out_valid_r, "skid word not advanced")

endmodule

`default_nettype wire

[hw/rtl/ordered_list_table_engine.sv]
// ----------------------------------------------------------------------------
// Ordered list table engine
// Shift-register list of signed 32-bit entries with insert, delete, search
// and reverse commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command word: action, position, value. out_ch returns
//   one result word per command: status, found_index, entry_count.
//   All cells shift, load, compare or take their mirror entry at the same
//   clock edge, so one command is accepted per cycle while the result
//   buffer is not full. Its result enters the output register, or the skid
//   register when an earlier result still waits, and then appears on out_ch.
//   A two-word result buffer sits in front of out_ch; in_ch.ready drops only
//   when both words are held, so a stalled receiver stops commands after at
//   most two pending results and nothing is dropped.
//   Synchronous reset empties the list and the result buffer; entry contents
//   are not cleared and are only read below the entry count.
//   Out-of-range positions return status 1, insert into a full list status
//   2, a search miss status 3; the list is left unchanged in those cases.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_table_engine_defines.svh"

module ordered_list_table_engine (
  input  wire        clk,
  input  wire        rst_n,
  olte_in_if.sink    in_ch,
  olte_out_if.source out_ch
);

  localparam int CAP = olte_pkg::CAPACITY;

  logic [olte_pkg::CNT_W-1:0]  n_r;
  logic [olte_pkg::CNT_W-1:0]  n_nxt;
  logic                        acc;
  logic                        buf_full;
  olte_pkg::action_t           act;
  logic [olte_pkg::POS_W-1:0]  pos;
  logic [olte_pkg::DATA_W-1:0] key;
  logic                        ins_ok;
  logic                        del_ok;
  logic                        rev_ok;
  logic                        hit;
  logic [olte_pkg::IDX_W-1:0]  hit_idx;
  olte_pkg::res_t              res;
  olte_pkg::res_t              out_res;

  olte_pkg::cell_ctrl_t        cell_ctrl [CAP];
  logic [olte_pkg::DATA_W-1:0] cell_val  [CAP];
  logic [olte_pkg::DATA_W-1:0] left_val  [CAP];
  logic [olte_pkg::DATA_W-1:0] right_val [CAP];
  logic [olte_pkg::DATA_W-1:0] mirror_val[CAP];
  logic [CAP-1:0]              match;
  logic [CAP-1:0]              match_q;
  logic [olte_pkg::CNT_W-1:0]  mirror_pos[CAP];

  assign in_ch.ready = !buf_full;
  assign acc         = in_ch.valid && !buf_full;
  assign act         = olte_pkg::action_t'(in_ch.action);
  assign pos         = in_ch.position;
  assign key         = in_ch.value;

  assign ins_ok = acc && (act == olte_pkg::ACT_INSERT) && (pos <= n_r)
                  && (n_r != olte_pkg::CNT_W'(CAP));
  assign del_ok = acc && (act == olte_pkg::ACT_DELETE) && (pos < n_r);
  assign rev_ok = acc && (act == olte_pkg::ACT_REVERSE);

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      mirror_pos[i]   = n_r - olte_pkg::CNT_W'(1) - olte_pkg::CNT_W'(i);
      cell_ctrl[i].key = key;
      cell_ctrl[i].op  = olte_pkg::CELL_HOLD;
      if (ins_ok) begin
        if (olte_pkg::CNT_W'(i) == pos) begin
          cell_ctrl[i].op = olte_pkg::CELL_LOAD;
        end else if (olte_pkg::CNT_W'(i) > pos && olte_pkg::CNT_W'(i) <= n_r) begin
          cell_ctrl[i].op = olte_pkg::CELL_UP;
        end
      end else if (del_ok) begin
        if (olte_pkg::CNT_W'(i) >= pos && olte_pkg::CNT_W'(i) + olte_pkg::CNT_W'(1) < n_r) begin
          cell_ctrl[i].op = olte_pkg::CELL_DOWN;
        end
      end else if (rev_ok) begin
        if (olte_pkg::CNT_W'(i) < n_r) begin
          cell_ctrl[i].op = olte_pkg::CELL_MIRROR;
        end
      end
    end
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_val[g] = '0;
    end else begin : g_left
      assign left_val[g] = cell_val[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign right_val[g] = '0;
    end else begin : g_right
      assign right_val[g] = cell_val[g+1];
    end
    assign mirror_val[g] = cell_val[mirror_pos[g][olte_pkg::IDX_W-1:0]];
    assign match_q[g]    = match[g] && (olte_pkg::CNT_W'(g) < n_r);

    olte_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .left_val   (left_val[g]),
      .right_val  (right_val[g]),
      .mirror_val (mirror_val[g]),
      .value      (cell_val[g]),
      .match      (match[g])
    );
  end

  always_comb begin
    hit     = |match_q;
    hit_idx = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = olte_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    n_nxt           = n_r;
    res.status      = olte_pkg::ST_OK;
    res.found_index = '0;
    case (act)
      olte_pkg::ACT_INSERT: begin
        if (pos > n_r) begin
          res.status = olte_pkg::ST_RANGE;
        end else if (n_r == olte_pkg::CNT_W'(CAP)) begin
          res.status = olte_pkg::ST_FULL;
        end else begin
          n_nxt = n_r + olte_pkg::CNT_W'(1);
        end
      end
      olte_pkg::ACT_DELETE: begin
        if (pos >= n_r) begin
          res.status = olte_pkg::ST_RANGE;
        end else begin
          n_nxt = n_r - olte_pkg::CNT_W'(1);
        end
      end
      olte_pkg::ACT_SEARCH: begin
        if (hit) begin
          res.found_index = hit_idx;
        end else begin
          res.status = olte_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        res.status = olte_pkg::ST_OK;
      end
    endcase
    res.entry_count = n_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (acc) begin
      n_r <= n_nxt;
    end
  end

  olte_resbuf u_resbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.status      = olte_pkg::STAT_W'(out_res.status);
  assign out_ch.found_index = out_res.found_index;
  assign out_ch.entry_count = out_res.entry_count;

  `OLTE_ASSERT(a_count_bound, clk, rst_n, n_r <= olte_pkg::CNT_W'(CAP), "entry count above capacity")
  `OLTE_ASSERT(a_insert_grows, clk, rst_n, ins_ok |=> (n_r == $past(n_r) + olte_pkg::CNT_W'(1)), "insert did not grow count")
  `OLTE_ASSERT(a_idle_holds, clk, rst_n, !acc |=> $stable(n_r), "count moved without command")

endmodule

`default_nettype wire

[dv/ordered_list_table_engine_checker.sv]
// ----------------------------------------------------------------------------
// Ordered list table engine checker
// Watches the command and result channels, keeps its own copy of the list,
// predicts one result word per accepted command and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_table_engine_checker
  import olte_pkg::*;
(
  input  wire clk,
  input  wire rst_n,
  olte_in_if  in_mon,
  olte_out_if out_mon,
  output int  fail_count,
  output int  pending_count,
  output int  words_checked,
  output int  range_seen,
  output int  full_seen,
  output int  miss_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] list_cells [CAPACITY];
  int unsigned       list_len;
  res_t              expected_q [$];

  function automatic res_t apply_command(action_t act, logic [POS_W-1:0] pos,
                                         logic [DATA_W-1:0] val);
    res_t              r;
    int unsigned       n;
    int                i;
    int                lo;
    int                hi;
    logic [DATA_W-1:0] t;
    r.status      = ST_OK;
    r.found_index = '0;
    n             = list_len;
    case (act)
      ACT_INSERT: begin
        if (pos > n) begin
          r.status = ST_RANGE;
        end else if (n >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = int'(n); i > int'(pos); i--) list_cells[i] = list_cells[i-1];
          list_cells[pos[IDX_W-1:0]] = val;
          list_len = n + 1;
        end
      end
      ACT_DELETE: begin
        if (pos >= n) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < int'(n); i++) list_cells[i] = list_cells[i+1];
          list_len = n - 1;
        end
      end
      ACT_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < int'(n); i++) begin
          if (r.status == ST_NOTFOUND && list_cells[i] === val) begin
            r.status      = ST_OK;
            r.found_index = i[IDX_W-1:0];
          end
        end
      end
      default: begin
        lo = 0;
        hi = int'(n) - 1;
        while (lo < hi) begin
          t              = list_cells[lo];
          list_cells[lo] = list_cells[hi];
          list_cells[hi] = t;
          lo++;
          hi--;
        end
      end
    endcase
    r.entry_count = list_len[CNT_W-1:0];
    return r;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    words_checked = 0;
    range_seen    = 0;
    full_seen     = 0;
    miss_seen     = 0;
    list_len      = 0;
  end

  always @(posedge clk) begin
    res_t exp_word;
    if (!rst_n) begin
      list_len = 0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(apply_command(action_t'(in_mon.action), in_mon.position,
                                           in_mon.value));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: status %0d index %0d count %0d",
                     out_mon.status, out_mon.found_index, out_mon.entry_count);
        end else begin
          exp_word = expected_q.pop_front();
          words_checked++;
          case (exp_word.status)
            ST_RANGE:    range_seen++;
            ST_FULL:     full_seen++;
            ST_NOTFOUND: miss_seen++;
            default: ;
          endcase
          if (out_mon.status !== exp_word.status ||
              out_mon.found_index !== exp_word.found_index ||
              out_mon.entry_count !== exp_word.entry_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch word %0d: exp st %0d idx %0d cnt %0d, got st %0d idx %0d cnt %0d",
                       words_checked, exp_word.status, exp_word.found_index,
                       exp_word.entry_count, out_mon.status, out_mon.found_index,
                       out_mon.entry_count);
          end
        end
      end
      pending_count = expected_q.size();
    end
  end

endmodule

`default_nettype wire

[dv/ordered_list_table_engine_test.sv]
// ----------------------------------------------------------------------------
// Ordered list table engine testbench
// Drives directed edge cases of insert, delete, search and reverse, then
// phases of random commands that grow, shrink and search the list, with
// random gaps and receiver stalls; a side checker predicts every result.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_table_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import olte_pkg::*;

  localparam int WORD_TARGET    = 1600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 200;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  olte_in_if  cmd_ch ();
  olte_out_if res_ch ();

  int check_fails;
  int pending_words;
  int words_checked;
  int range_seen;
  int full_seen;
  int miss_seen;

  ordered_list_table_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  ordered_list_table_engine_checker list_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (cmd_ch),
    .out_mon       (res_ch),
    .fail_count    (check_fails),
    .pending_count (pending_words),
    .words_checked (words_checked),
    .range_seen    (range_seen),
    .full_seen     (full_seen),
    .miss_seen     (miss_seen)
  );

  int                words_sent = 0;
  int                shadow_len = 0;
  int                holds_done = 0;
  int                idle_cycles = 0;
  int                cmd_tally [4] = '{0, 0, 0, 0};
  bit                tx_burst = 1'b0;
  logic [DATA_W-1:0] value_pool [8];

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic send_word(action_t act, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
    int gap;
    gap = tx_burst ? 0 : gap_len();
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid    = 1'b1;
    cmd_ch.action   = act;
    cmd_ch.position = pos;
    cmd_ch.value    = val;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
    case (act)
      ACT_INSERT: if (pos <= shadow_len && shadow_len < CAPACITY) shadow_len++;
      ACT_DELETE: if (pos < shadow_len) shadow_len--;
      default: ;
    endcase
    cmd_tally[int'(act)]++;
    words_sent++;
  endtask

  task automatic random_phase();
    int               kind;
    int               len;
    int               ins_w;
    int               del_w;
    int               srch_w;
    int               r;
    int               k;
    action_t          act;
    logic [POS_W-1:0] pos;
    kind     = $urandom_range(0, 3);
    len      = $urandom_range(20, 60);
    tx_burst = ($urandom_range(0, 3) == 0);
    case (kind)
      0:       begin ins_w = 70; del_w = 10; srch_w = 15; end
      1:       begin ins_w = 10; del_w = 70; srch_w = 15; end
      2:       begin ins_w = 35; del_w = 30; srch_w = 25; end
      default: begin ins_w = 20; del_w = 15; srch_w = 55; end
    endcase
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < ins_w) act = ACT_INSERT;
      else if (r < ins_w + del_w) act = ACT_DELETE;
      else if (r < ins_w + del_w + srch_w) act = ACT_SEARCH;
      else act = ACT_REVERSE;
      if ($urandom_range(0, 99) < 15 || act == ACT_SEARCH || act == ACT_REVERSE)
        pos = POS_W'($urandom_range(0, 31));
      else if (act == ACT_INSERT)
        pos = POS_W'($urandom_range(0, shadow_len));
      else
        pos = (shadow_len > 0) ? POS_W'($urandom_range(0, shadow_len - 1)) : '0;
      if ($urandom_range(0, 19) == 0) value_pool[$urandom_range(0, 7)] = $urandom;
      send_word(act, pos, pick_value());
    end
  endtask

  initial begin
    int r;
    int run;
    int next_hold;
    res_ch.ready = 1'b0;
    next_hold    = 300;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (holds_done < 2 && words_sent >= next_hold) begin
        res_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
        next_hold += 600;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          res_ch.ready = 1'b1;
          run = $urandom_range(1, 40);
        end else if (r < 80) begin
          res_ch.ready = 1'($urandom_range(0, 1));
          run = 1;
        end else if (r < 95) begin
          res_ch.ready = 1'b0;
          run = $urandom_range(1, 4);
        end else begin
          res_ch.ready = 1'b0;
          run = $urandom_range(15, 40);
        end
        repeat (run) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles with no word moving", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_ch.valid    = 1'b0;
    cmd_ch.action   = ACT_INSERT;
    cmd_ch.position = '0;
    cmd_ch.value    = '0;
    value_pool[0]   = 32'h8000_0000;
    value_pool[1]   = 32'h7FFF_FFFF;
    value_pool[2]   = 32'h0000_0000;
    value_pool[3]   = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list
    send_word(ACT_SEARCH,  5'd0,  32'h0000_0000);
    send_word(ACT_DELETE,  5'd0,  32'h0000_0000);
    send_word(ACT_REVERSE, 5'd0,  32'h0000_0000);
    send_word(ACT_INSERT,  5'd1,  32'h1234_5678);
    // build and search with duplicates
    send_word(ACT_INSERT,  5'd0,  32'h8000_0000);
    send_word(ACT_REVERSE, 5'd0,  32'h0000_0000);
    send_word(ACT_INSERT,  5'd1,  32'h7FFF_FFFF);
    send_word(ACT_INSERT,  5'd1,  32'h0000_0000);
    send_word(ACT_INSERT,  5'd0,  32'hFFFF_FFFF);
    send_word(ACT_INSERT,  5'd2,  32'h0000_0000);
    send_word(ACT_SEARCH,  5'd0,  32'h0000_0000);
    send_word(ACT_SEARCH,  5'd0,  32'h7FFF_FFFF);
    send_word(ACT_SEARCH,  5'd0,  32'h0000_0001);
    send_word(ACT_REVERSE, 5'd0,  32'h0000_0000);
    send_word(ACT_SEARCH,  5'd0,  32'h8000_0000);
    // out-of-range positions
    send_word(ACT_DELETE,  5'd5,  32'h0000_0000);
    send_word(ACT_DELETE,  5'd31, 32'hFFFF_FFFF);
    send_word(ACT_INSERT,  5'd31, 32'hA5A5_A5A5);
    send_word(ACT_INSERT,  5'd6,  32'h5A5A_5A5A);
    // shrink from both ends and the middle
    send_word(ACT_DELETE,  5'd4,  32'h0000_0000);
    send_word(ACT_DELETE,  5'd0,  32'h0000_0000);
    send_word(ACT_SEARCH,  5'd31, 32'h0000_0000);
    send_word(ACT_REVERSE, 5'd17, $urandom);
    send_word(ACT_DELETE,  5'd1,  32'h0000_0000);

    while (words_sent < WORD_TARGET) random_phase();
    cmd_ch.valid = 1'b0;

    do @(negedge clk); while (pending_words != 0);
    repeat (8) @(negedge clk);

    $display("run: %0d cmds (ins %0d, del %0d, srch %0d, rev %0d), %0d results checked",
             words_sent, cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3], words_checked);
    $display("run: %0d range, %0d full, %0d miss results, %0d long receiver stalls",
             range_seen, full_seen, miss_seen, holds_done);
    if (check_fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
